FILE: src/emb_pkg.sv
// shared types and constants for the 3x3 emboss filter
`timescale 1ns / 1ps

package emb_pkg;

  // one raster pixel, also the word kept in each line store
  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pix_in_t;

  // one filtered pixel
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_done;
  } pix_out_t;

  localparam int unsigned FrameWidthW  = 11;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned RowW         = 12;
  localparam int unsigned CfgAddrW     = 2;
  localparam int unsigned CfgDataW     = 13;
  localparam int unsigned PixW         = $bits(pix_in_t);

  // register indexes on the config port
  localparam logic [CfgAddrW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgAddrW-1:0] RegFrameHeight = 2'd1;

  localparam logic [FrameWidthW-1:0]  FrameWidthRst  = 11'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightRst = 13'd480;
  localparam logic [FrameHeightW-1:0] MaxHeight      = 13'd4096;
  localparam logic [FrameHeightW-1:0] MinSize        = 13'd3;

endpackage

FILE: src/emb_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module emb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/emb_lane.sv
// one color lane: emboss kernel on a 3x3 window of 8-bit samples, clamped
`timescale 1ns / 1ps

module emb_lane (
  input  logic [7:0] top0_i,
  input  logic [7:0] top1_i,
  input  logic [7:0] mid0_i,
  input  logic [7:0] mid1_i,
  input  logic [7:0] mid2_i,
  input  logic [7:0] bot1_i,
  input  logic [7:0] bot2_i,
  output logic [7:0] res_o
);

  logic [10:0]        pos;
  logic [10:0]        neg;
  logic signed [11:0] sum;

  // kernel {-2,-1,0; -1,1,1; 0,1,2}, the top right and bottom left taps are zero
  always_comb begin
    pos = {3'b0, mid1_i} + {3'b0, mid2_i} + {3'b0, bot1_i} + {2'b0, bot2_i, 1'b0};
    neg = {2'b0, top0_i, 1'b0} + {3'b0, top1_i} + {3'b0, mid0_i};
    sum = $signed({1'b0, pos}) - $signed({1'b0, neg});
    if (sum < 12'sd0) begin
      res_o = 8'd0;
    end else if (sum > 12'sd255) begin
      res_o = 8'd255;
    end else begin
      res_o = sum[7:0];
    end
  end

endmodule

FILE: src/emboss_3x3_convolution_rgb.sv
// top level: raster emboss filter with line stores, window and three color lanes
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o | in_data_i   (pix_in_t)
//  out     | source    | out_valid_o/ out_stall_i| out_data_o  (pix_out_t)
//  cfg     | sink      | cfg_valid_i/ cfg_ready_o| cfg_addr_i, cfg_data_i
//
// one pixel per clock while the output is not stalled; a pixel's result passes the
// read stage (line store read), then the lane adders into the output register
// the line store read port sets the pipeline: one read per pixel, written back
// when the pixel leaves the read stage
// reset clears counters, valids and the frame size (640 x 480); the line stores
// are not cleared, the first two rows never produce a result
// a stalled output holds the read stage, and the input stalls once both are full
`timescale 1ns / 1ps

module emboss_3x3_convolution_rgb
  import emb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pix_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pix_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam logic [FrameHeightW-1:0] MaxWidth = FrameHeightW'(MAX_WIDTH);

  // frame size registers
  logic [FrameWidthW-1:0]  frame_width_q;
  logic [FrameHeightW-1:0] frame_height_q;
  logic [FrameHeightW-1:0] width_ext;
  logic [FrameHeightW-1:0] width_eff;
  logic [FrameHeightW-1:0] height_eff;
  logic [ColW-1:0]         col_last;
  logic [RowW-1:0]         row_last;
  logic                    cfg_wr;
  logic                    restart;

  // raster position of the next pixel
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  // read stage: pixel waiting for its line store data
  logic            s1_valid_q;
  pix_in_t         s1_pix_q;
  logic [ColW-1:0] s1_col_q;
  logic            s1_emit_q;
  logic            s1_last_q;
  logic            s1_adv;
  logic            in_acc;

  pix_in_t up_rd;
  pix_in_t mid_rd;

  // two previous columns of the strip: 0..2 = col-2 top/mid/bot, 3..5 = col-1
  pix_in_t win_q [6];

  logic [2:0][7:0] lane_res;

  logic     out_valid_q, out_valid_d;
  pix_out_t out_q;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_wr &&
                       (cfg_addr_i == RegFrameWidth || cfg_addr_i == RegFrameHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_wr) begin
      case (cfg_addr_i)
        RegFrameWidth:  frame_width_q  <= cfg_data_i[FrameWidthW-1:0];
        RegFrameHeight: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // out-of-range sizes clamp to 3..MAX_WIDTH and 3..4096
  always_comb begin
    width_ext = {{(FrameHeightW-FrameWidthW){1'b0}}, frame_width_q};
    if (width_ext < MinSize) begin
      width_eff = MinSize;
    end else if (width_ext > MaxWidth) begin
      width_eff = MaxWidth;
    end else begin
      width_eff = width_ext;
    end
    if (frame_height_q < MinSize) begin
      height_eff = MinSize;
    end else if (frame_height_q > MaxHeight) begin
      height_eff = MaxHeight;
    end else begin
      height_eff = frame_height_q;
    end
  end

  assign col_last = ColW'(width_eff - 13'd1);
  assign row_last = RowW'(height_eff - 13'd1);

  // ---------------------------------------------------------------- handshakes
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------- position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_q == col_last) begin
        col_d = '0;
        row_d = (row_q == row_last) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------- read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q  <= in_data_i;
      s1_col_q  <= col_q;
      // a full window exists from the third row and third column on
      s1_emit_q <= (row_q >= RowW'(2)) && (col_q >= ColW'(2));
      s1_last_q <= (row_q == row_last) && (col_q == col_last);
    end
  end

  // line stores: read at acceptance, written back when the pixel moves on;
  // the middle row's old entry shifts up, the new pixel takes its place
  emb_ram #(
    .WIDTH (PixW),
    .DEPTH (MAX_WIDTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (mid_rd),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  emb_ram #(
    .WIDTH (PixW),
    .DEPTH (MAX_WIDTH)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  // window shifts left by one column per pixel; contents before the third
  // column of a row never reach an output
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= up_rd;
      win_q[4] <= mid_rd;
      win_q[5] <= s1_pix_q;
    end
  end

  // ---------------------------------------------------------------- lanes
  // lane 2 red, lane 1 green, lane 0 blue
  for (genvar k = 0; k < 3; k++) begin : g_lane
    emb_lane u_lane (
      .top0_i (win_q[0][8*k +: 8]),
      .top1_i (win_q[3][8*k +: 8]),
      .mid0_i (win_q[1][8*k +: 8]),
      .mid1_i (win_q[4][8*k +: 8]),
      .mid2_i (mid_rd[8*k +: 8]),
      .bot1_i (win_q[5][8*k +: 8]),
      .bot2_i (s1_pix_q[8*k +: 8]),
      .res_o  (lane_res[k])
    );
  end

  // ---------------------------------------------------------------- merge / output
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_emit_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      out_q.out_red    <= lane_res[2];
      out_q.out_green  <= lane_res[1];
      out_q.out_blue   <= lane_res[0];
      out_q.frame_done <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- checks
  // the write-back never hits the entry being read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && in_acc) |-> (s1_col_q != col_q))
    else $error("line store read and write collide");

  // the column counter never runs past the last column of the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (col_q <= col_last))
    else $error("column counter out of range");

  // a blocked read stage must not take a new item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> !in_acc)
    else $error("item accepted into a full pipeline");

  // an output is loaded only from a read stage that held an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && out_valid_d) |-> s1_valid_q)
    else $error("output appeared without a source item");

endmodule
